// ===== rtl/petb_pkg.sv =====
// shared constants and types for the periodic event timer bank
// no dependencies; the timer, bank and bench files import this package
package petb_pkg;

    localparam int EVENTS   = 8;
    localparam int IDX_W    = (EVENTS > 1) ? $clog2(EVENTS) : 1;
    localparam int OP_W     = 2;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 17;
    localparam int DONE_W   = 8;
    localparam int MASK_W   = 8;
    localparam int MASK_USED = (EVENTS < MASK_W) ? EVENTS : MASK_W;

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_CONFIGURE = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK       = 2'd2;

    // last done count before it wraps back to zero
    localparam logic [DONE_W-1:0] DONE_LAST = 8'd254;
    localparam logic [DONE_W-1:0] DONE_BAD  = 8'd255;

    typedef struct packed {
        logic step;
        logic tick;
        logic cfg;
        logic ack;
    } petb_cmd_t;

endpackage

// ===== rtl/petb_if.sv =====
// valid/ready channel interfaces for the timer bank's command and result items
// depends on nothing but the field widths of the block
interface petb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  timer_id;
    logic        enable;
    logic [15:0] period;

    modport source (output valid, op, timer_id, enable, period, input ready);
    modport sink (input valid, op, timer_id, enable, period, output ready);
endinterface

interface petb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ready_mask;
    logic [7:0] done_count;

    modport source (output valid, ready_mask, done_count, input ready);
    modport sink (input valid, ready_mask, done_count, output ready);
endinterface

// ===== rtl/petb_timer.sv =====
// one event timer: enable, period, tick counter, ready flag and done count
// depends on petb_pkg
module petb_timer
    import petb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  petb_cmd_t           cmd,
    input  logic                enable,
    input  logic [PERIOD_W-1:0] period,
    output logic                flag_next,
    output logic [DONE_W-1:0]   done_next
);

    logic                enabled_reg, enabled_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                flag_reg;
    logic [DONE_W-1:0]   done_reg;
    logic [COUNT_W-1:0]  count_inc;

    assign count_inc = count_reg + COUNT_W'(1);

    always_comb
    begin
        enabled_next = enabled_reg;
        period_next  = period_reg;
        count_next   = count_reg;
        flag_next    = flag_reg;
        done_next    = done_reg;
        if (cmd.tick)
        begin
            if (enabled_reg)
            begin
                count_next = count_inc;
                if (count_inc > {1'b0, period_reg})
                begin
                    flag_next  = 1'b1;
                    count_next = '0;
                end
            end
            else
            begin
                flag_next  = 1'b0;
                count_next = '0;
            end
        end
        else if (cmd.cfg)
        begin
            enabled_next = enable;
            period_next  = period;
            count_next   = '0;
            done_next    = '0;
        end
        else if (cmd.ack)
        begin
            flag_next = 1'b0;
            done_next = (done_reg >= DONE_LAST) ? '0 : done_reg + DONE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            period_reg  <= '0;
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            done_reg    <= '0;
        end
        else if (cmd.step)
        begin
            enabled_reg <= enabled_next;
            period_reg  <= period_next;
            count_reg   <= count_next;
            flag_reg    <= flag_next;
            done_reg    <= done_next;
        end
    end

endmodule

// ===== rtl/periodic_event_timer_bank.sv =====
// Bank of EVENTS periodic event timers driven by tick, configure and
// acknowledge items; each item returns the ready flags of events 0..7 and the
// done count of the addressed event. An item is held in the input register,
// then all per-event counters and compares update in parallel into the
// result register, from which its result is offered; a new item can be
// taken every clock cycle while the result side does not stall.
// Stalls on the result side hold the input register and drop ready on the
// command side.
module periodic_event_timer_bank
    import petb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    petb_in_if.sink           in_ch,
    petb_out_if.source        out_ch
);

    logic                in_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic                en_reg;
    logic [PERIOD_W-1:0] per_reg;

    logic                out_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg, out_mask_next;
    logic [DONE_W-1:0]   out_done_reg, out_done_next;

    logic                step;
    logic                id_ok;
    logic [IDX_W-1:0]    idx;
    logic [EVENTS-1:0]   flag_next;
    logic [DONE_W-1:0]   done_next [EVENTS];
    petb_cmd_t           cmd [EVENTS];

    assign step        = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || step;

    assign id_ok = (32'(id_reg) < EVENTS);
    assign idx   = IDX_W'(id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg  <= in_ch.op;
            id_reg  <= in_ch.timer_id;
            en_reg  <= in_ch.enable;
            per_reg <= in_ch.period;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < EVENTS; gi++)
        begin : g_event
            logic hit;
            assign hit = id_ok && (idx == IDX_W'(gi));
            assign cmd[gi] = '{
                step: step,
                tick: (op_reg == OP_TICK),
                cfg:  (op_reg == OP_CONFIGURE) && hit,
                ack:  (op_reg == OP_ACK) && hit
            };

            petb_timer u_timer (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd[gi]),
                .enable    (en_reg),
                .period    (per_reg),
                .flag_next (flag_next[gi]),
                .done_next (done_next[gi])
            );
        end

        // only events 0..7 show in the mask
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < EVENTS)
            begin : g_used
                assign out_mask_next[gi] = flag_next[gi];
            end
            else
            begin : g_unused
                assign out_mask_next[gi] = 1'b0;
            end
        end
    endgenerate

    assign out_done_next = id_ok ? done_next[idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_mask_reg <= out_mask_next;
            out_done_reg <= out_done_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.ready_mask = out_mask_reg;
    assign out_ch.done_count = out_done_reg;

    // an accepted item always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> in_valid_reg)
        else $error("accepted item lost before the input register");

    // a pending item waits while the result register is stalled
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ch.ready |=> in_valid_reg && $stable(op_reg))
        else $error("pending item dropped during a result stall");

    // a completed step always leaves a result behind
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("step finished without a result");

    // done count never shows the unused value 255
    a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_done_reg != DONE_BAD)
        else $error("done count out of range");

    // mask bits above the bank stay clear
    a_mask_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_mask_reg >> MASK_USED) == '0)
        else $error("ready flag shown for a missing event");

endmodule

// ===== bench/periodic_event_timer_bank_checker.sv =====
`timescale 1ns / 100ps
// result checker for the periodic event timer bank: watches both channels,
// predicts each result from its own copy of the timer state. needs petb_pkg, petb_if
module periodic_event_timer_bank_checker
    import petb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    petb_in_if   in_ch,
    petb_out_if  out_ch,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [MASK_W-1:0] ready_mask;
        logic [DONE_W-1:0] done_count;
    } timer_status_t;

    timer_status_t status_queue[$];

    logic                ev_enabled [EVENTS];
    logic [PERIOD_W-1:0] ev_period  [EVENTS];
    logic [COUNT_W-1:0]  ev_count   [EVENTS];
    logic                ev_ready   [EVENTS];
    logic [DONE_W-1:0]   ev_done    [EVENTS];

    function automatic timer_status_t advance_timers(
        input logic [OP_W-1:0]     op,
        input logic [ID_W-1:0]     id,
        input logic                en,
        input logic [PERIOD_W-1:0] per
    );
        timer_status_t status;
        logic          id_ok;
        id_ok  = int'(id) < EVENTS;
        status = '0;
        if (op == OP_TICK)
        begin
            for (int i = 0; i < EVENTS; i++)
            begin
                if (ev_enabled[i])
                begin
                    ev_count[i] = ev_count[i] + COUNT_W'(1);
                    if (ev_count[i] > {1'b0, ev_period[i]})
                    begin
                        ev_ready[i] = 1'b1;
                        ev_count[i] = '0;
                    end
                end
                else
                begin
                    ev_ready[i] = 1'b0;
                    ev_count[i] = '0;
                end
            end
        end
        else if (op == OP_CONFIGURE && id_ok)
        begin
            // ready flag is left alone here
            ev_enabled[id] = en;
            ev_period[id]  = per;
            ev_count[id]   = '0;
            ev_done[id]    = '0;
        end
        else if (op == OP_ACK && id_ok)
        begin
            ev_done[id]  = (ev_done[id] == DONE_LAST) ? '0 : ev_done[id] + DONE_W'(1);
            ev_ready[id] = 1'b0;
        end
        for (int i = 0; i < EVENTS && i < MASK_W; i++)
            status.ready_mask[i] = ev_ready[i];
        status.done_count = id_ok ? ev_done[id] : '0;
        return status;
    endfunction

    function automatic void note_mismatch(input string what, input timer_status_t want,
                                          input timer_status_t got);
        if (mismatches < 10)
            $display("%0t mismatch (%s): expected mask %h done %0d, got mask %h done %0d",
                     $realtime, what, want.ready_mask, want.done_count,
                     got.ready_mask, got.done_count);
        mismatches <= mismatches + 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_status_t got;
        timer_status_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < EVENTS; i++)
            begin
                ev_enabled[i] = 1'b0;
                ev_period[i]  = '0;
                ev_count[i]   = '0;
                ev_ready[i]   = 1'b0;
                ev_done[i]    = '0;
            end
            status_queue.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.ready_mask = out_ch.ready_mask;
                got.done_count = out_ch.done_count;
                if (status_queue.size() == 0)
                begin
                    want = 'x;
                    note_mismatch("result with no item pending", want, got);
                end
                else
                begin
                    want = status_queue.pop_front();
                    if (got.ready_mask !== want.ready_mask)
                        note_mismatch("ready_mask", want, got);
                    else if (got.done_count !== want.done_count)
                        note_mismatch("done_count", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready)
                status_queue.push_back(advance_timers(in_ch.op, in_ch.timer_id,
                                                      in_ch.enable, in_ch.period));
            outstanding <= status_queue.size();
        end
    end

endmodule

// ===== bench/periodic_event_timer_bank_test.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the periodic event timer bank, needs petb_pkg, petb_if and
// periodic_event_timer_bank_checker; drives tick, configure, ack and unused items
module periodic_event_timer_bank_test;
    import petb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic idle_on;
    logic hold_off_req;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;

    petb_in_if  cmd_ch ();
    petb_out_if status_ch ();

    periodic_event_timer_bank dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (status_ch)
    );

    periodic_event_timer_bank_checker timer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (cmd_ch),
        .out_ch      (status_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        status_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                status_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            status_ch.ready <= !(idle_on && $urandom_range(99) < 31);
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic en, input logic [PERIOD_W-1:0] per);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 31)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.op       <= op;
        cmd_ch.timer_id <= id;
        cmd_ch.enable   <= en;
        cmd_ch.period   <= per;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // sender stops until every result is back
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return PERIOD_W'($urandom_range(7));
        else if (roll < 80)
            return PERIOD_W'($urandom_range(300, 8));
        else if (roll < 90)
            return PERIOD_W'($urandom);
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return 16'd1;
            default: return 16'hfffe;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return OP_TICK;
        else if (roll < 60)
            return OP_CONFIGURE;
        else if (roll < 95)
            return OP_ACK;
        return OP_UNUSED;
    endfunction

    initial
    begin
        int acks_sent;
        logic [OP_W-1:0] op;

        rst_n           = 1'b0;
        idle_on         = 1'b1;
        hold_off_req    = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.op       = OP_TICK;
        cmd_ch.timer_id = '0;
        cmd_ch.enable   = 1'b0;
        cmd_ch.period   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_cmd(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_cmd(OP_CONFIGURE, 3'd0, 1'b1, 16'd0);
        send_cmd(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_cmd(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_cmd(OP_ACK, 3'd0, 1'b0, 16'd0);
        send_cmd(OP_CONFIGURE, 3'd7, 1'b1, 16'hffff);
        send_cmd(OP_CONFIGURE, 3'd3, 1'b1, 16'd1);
        send_cmd(OP_TICK, 3'd3, 1'b0, 16'd0);
        send_cmd(OP_TICK, 3'd3, 1'b0, 16'd0);
        send_cmd(OP_UNUSED, 3'd3, 1'b1, 16'hffff);
        // disabling a ready event keeps its flag until the next tick
        send_cmd(OP_CONFIGURE, 3'd3, 1'b0, 16'd2);
        send_cmd(OP_TICK, 3'd3, 1'b1, 16'hffff);
        send_cmd(OP_ACK, 3'd7, 1'b1, 16'hffff);
        send_cmd(OP_CONFIGURE, 3'd5, 1'b1, 16'h5555);
        send_cmd(OP_CONFIGURE, 3'd6, 1'b1, 16'haaaa);
        send_cmd(OP_TICK, 3'd6, 1'b0, 16'd0);
        send_cmd(OP_UNUSED, 3'd5, 1'b1, 16'hffff);
        send_cmd(OP_ACK, 3'd2, 1'b1, 16'hffff);
        send_cmd(OP_CONFIGURE, 3'd0, 1'b0, 16'd0);
        send_cmd(OP_TICK, 3'd0, 1'b0, 16'd0);
        wait_drained();

        // run one done count past its wrap at 254, no idling here
        idle_on = 1'b0;
        send_cmd(OP_CONFIGURE, 3'd4, 1'b1, 16'd0);
        acks_sent = 0;
        while (acks_sent < 260)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_cmd(OP_ACK, 3'd4, 1'($urandom), PERIOD_W'($urandom));
                acks_sent++;
            end
            else
            begin
                send_cmd(OP_TICK, ID_W'($urandom), 1'($urandom), PERIOD_W'($urandom));
            end
        end
        idle_on = 1'b1;

        hold_off_req = 1'b1;
        for (int n = 0; n < 1500; n++)
        begin
            op = pick_op();
            if (op == OP_CONFIGURE)
                send_cmd(op, ID_W'($urandom), $urandom_range(99) < 80, pick_period());
            else
                send_cmd(op, ID_W'($urandom), 1'($urandom), PERIOD_W'($urandom));
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
